@@ sv/slv_pkg.sv @@
// ----------------------------------------------------------------------------
// Sorter package
// Shared widths, defaults and the control word that drives the sorting cells.
// ----------------------------------------------------------------------------
`default_nettype none

package slv_pkg;

    localparam int DATA_W    = 32;
    localparam int DEPTH_DEF = 64;

    typedef struct packed {
        logic insert;
        logic shift;
    } cell_ctrl_t;

endpackage

`default_nettype wire

@@ sv/sort_loaded_values_core.sv @@
// ----------------------------------------------------------------------------
// Loaded value sorter
// Inserts words into an ordered row of cells till full; streams the row out.
// ----------------------------------------------------------------------------
// Each word is placed in order on arrival. The first result follows the cycle
// after the closing word, then one result per cycle until every stored word
// is out.
// busy is high while results stream out; the receiver cannot stall.
// Reset empties the row and clears the count and the dropped flag.
`default_nettype none

module sort_loaded_values_core #(
    parameter int DEPTH = slv_pkg::DEPTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic signed [slv_pkg::DATA_W-1:0] value,
    input  wire logic                              is_last,
    output logic                                   valid,
    output logic signed [slv_pkg::DATA_W-1:0]      sorted_value,
    output logic                                   last_out,
    output logic                                   overflow
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0] fill_reg;
    logic [CW-1:0] fill_next;
    logic          dropped_reg;
    logic          dropped_next;
    logic          emit_reg;
    logic          emit_next;

    logic          accept;
    logic          full;
    logic          final_emit;

    slv_pkg::cell_ctrl_t ctrl;

    logic signed [slv_pkg::DATA_W-1:0] cell_data [DEPTH];
    logic                              cell_valid [DEPTH];
    logic                              cell_take [DEPTH];

    assign busy       = emit_reg;
    assign accept     = start && !busy;
    assign full       = (fill_reg == CW'(DEPTH));
    assign final_emit = emit_reg && (fill_reg == CW'(1));

    assign ctrl.insert = accept && !full;
    assign ctrl.shift  = emit_reg;

    always_comb
    begin
        fill_next    = fill_reg;
        dropped_next = dropped_reg;
        emit_next    = emit_reg;
        if (emit_reg)
        begin
            fill_next = fill_reg - CW'(1);
            if (final_emit)
            begin
                dropped_next = 1'b0;
                emit_next    = 1'b0;
            end
        end
        else if (accept)
        begin
            if (full)
            begin
                dropped_next = 1'b1;
            end
            else
            begin
                fill_next = fill_reg + CW'(1);
            end
            if (is_last)
            begin
                emit_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            dropped_reg <= 1'b0;
            emit_reg    <= 1'b0;
        end
        else
        begin
            fill_reg    <= fill_next;
            dropped_reg <= dropped_next;
            emit_reg    <= emit_next;
        end
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic                              l_valid;
        logic                              l_take;
        logic signed [slv_pkg::DATA_W-1:0] l_data;
        logic                              r_valid;
        logic signed [slv_pkg::DATA_W-1:0] r_data;

        if (i == 0)
        begin : g_head
            assign l_valid = 1'b1;
            assign l_take  = 1'b0;
            assign l_data  = value;
        end
        else
        begin : g_body
            assign l_valid = cell_valid[i-1];
            assign l_take  = cell_take[i-1];
            assign l_data  = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign r_valid = 1'b0;
            assign r_data  = value;
        end
        else
        begin : g_inner
            assign r_valid = cell_valid[i+1];
            assign r_data  = cell_data[i+1];
        end

        slv_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .in_value    (value),
            .left_valid  (l_valid),
            .left_take   (l_take),
            .left_data   (l_data),
            .right_valid (r_valid),
            .right_data  (r_data),
            .data        (cell_data[i]),
            .valid       (cell_valid[i]),
            .take        (cell_take[i])
        );
    end

    assign valid        = emit_reg;
    assign sorted_value = cell_data[0];
    assign last_out     = final_emit;
    assign overflow     = dropped_reg;

endmodule

`default_nettype wire

@@ sv/slv_cell.sv @@
// ----------------------------------------------------------------------------
// Sorting cell
// Holds one word of the ordered row; takes part in insertion and shifting.
// ----------------------------------------------------------------------------
`default_nettype none

module slv_cell (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire slv_pkg::cell_ctrl_t               ctrl,
    input  wire logic signed [slv_pkg::DATA_W-1:0] in_value,
    input  wire logic                              left_valid,
    input  wire logic                              left_take,
    input  wire logic signed [slv_pkg::DATA_W-1:0] left_data,
    input  wire logic                              right_valid,
    input  wire logic signed [slv_pkg::DATA_W-1:0] right_data,
    output logic signed [slv_pkg::DATA_W-1:0]      data,
    output logic                                   valid,
    output logic                                   take
);

    logic signed [slv_pkg::DATA_W-1:0] data_reg;
    logic signed [slv_pkg::DATA_W-1:0] data_next;
    logic                              valid_reg;
    logic                              valid_next;

    // An empty cell counts as holding a value above every word.
    assign take  = !valid_reg || (in_value < data_reg);
    assign data  = data_reg;
    assign valid = valid_reg;

    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        if (ctrl.shift)
        begin
            data_next  = right_data;
            valid_next = right_valid;
        end
        else if (ctrl.insert)
        begin
            valid_next = valid_reg | left_valid;
            if (take)
            begin
                data_next = left_take ? left_data : in_value;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

`default_nettype wire

@@ sim/sort_loaded_values_core_tb.sv @@
// ----------------------------------------------------------------------------
// Loaded value sorter testbench
// Loads sets of signed words, each closed by a flagged word, and checks that
// every set streams back in ascending order with the closing and dropped
// flags set as expected. A directed table comes first, then random sets of
// mostly small sizes with a few that fill or overrun the store. Results not
// typed in the table are checked against an in-order model of the stored set.
// ----------------------------------------------------------------------------

module sort_loaded_values_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DATA_W       = slv_pkg::DATA_W;
    localparam int DEPTH        = slv_pkg::DEPTH_DEF;
    localparam int RANDOM_WORDS = 380;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 2 * DEPTH + 16;
    localparam int TABLE_ROWS   = 12;

    localparam logic signed [DATA_W-1:0] MIN_WORD = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] MAX_WORD = {1'b0, {(DATA_W-1){1'b1}}};

    typedef struct packed {
        logic signed [DATA_W-1:0] word;
        logic                     last;
        logic                     ovf;
    } sorted_word_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] word;
        logic                     last;
        logic                     typed;
        logic signed [DATA_W-1:0] exp_word;
        logic                     exp_last;
        logic                     exp_ovf;
    } stim_row_t;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic signed [DATA_W-1:0] value;
    logic                     is_last;
    logic                     valid;
    logic signed [DATA_W-1:0] sorted_value;
    logic                     last_out;
    logic                     overflow;

    logic signed [DATA_W-1:0] held_words [DEPTH];
    int                       held_count;
    logic                     dropped;
    sorted_word_t             sorted_words_due [$];
    sorted_word_t             head;
    stim_row_t                directed_rows [TABLE_ROWS];
    bit                       mismatch_seen;
    int                       cycle_count;

    sort_loaded_values_core #(
        .DEPTH(DEPTH)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .value       (value),
        .is_last     (is_last),
        .valid       (valid),
        .sorted_value(sorted_value),
        .last_out    (last_out),
        .overflow    (overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Keeps the stored set in ascending order and, on the closing word,
    // queues the whole set as the results due.
    task automatic load_word(input logic signed [DATA_W-1:0] w, input logic l);
        int           j;
        int           k;
        sorted_word_t entry;
        if (held_count < DEPTH)
        begin
            j = held_count;
            while (j > 0 && held_words[j-1] > w)
            begin
                held_words[j] = held_words[j-1];
                j--;
            end
            held_words[j] = w;
            held_count++;
        end
        else
        begin
            dropped = 1'b1;
        end
        if (l)
        begin
            for (k = 0; k < held_count; k++)
            begin
                entry.word = held_words[k];
                entry.last = (k == held_count - 1);
                entry.ovf  = dropped;
                sorted_words_due.push_back(entry);
            end
            held_count = 0;
            dropped    = 1'b0;
        end
    endtask

    task automatic send_word(input logic signed [DATA_W-1:0] w, input logic l);
        start   <= 1'b1;
        value   <= w;
        is_last <= l;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic pause(input int pct);
        if ($urandom_range(0, 99) < pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    function automatic logic signed [DATA_W-1:0] random_word();
        case ($urandom_range(0, 5))
            0: return MIN_WORD;
            1: return MAX_WORD;
            2: return int'($urandom_range(0, 8)) - 4;
            default: return $urandom;
        endcase
    endfunction

    function automatic int gap_percent(input int sent);
        if (sent < RANDOM_WORDS / 3)
            return 6;
        else if (sent < 2 * RANDOM_WORDS / 3)
            return 48;
        else
            return 0;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && valid)
        begin
            if (sorted_words_due.size() == 0)
            begin
                $display("%0t: unexpected word, actual %0d last %0b overflow %0b",
                         $time, sorted_value, last_out, overflow);
                mismatch_seen = 1'b1;
            end
            else
            begin
                head = sorted_words_due.pop_front();
                if (sorted_value !== head.word)
                begin
                    $display("%0t: sorted_value expected %0d actual %0d",
                             $time, head.word, sorted_value);
                    mismatch_seen = 1'b1;
                end
                if (last_out !== head.last)
                begin
                    $display("%0t: last_out expected %0b actual %0b",
                             $time, head.last, last_out);
                    mismatch_seen = 1'b1;
                end
                if (overflow !== head.ovf)
                begin
                    $display("%0t: overflow expected %0b actual %0b",
                             $time, head.ovf, overflow);
                    mismatch_seen = 1'b1;
                end
            end
        end
    end

    initial
    begin
        stim_row_t                row;
        sorted_word_t             typed_word;
        logic signed [DATA_W-1:0] w;
        logic                     l;
        int                       i;
        int                       n;
        int                       set_size;
        int                       set_index;
        int                       random_sent;

        rst_n         = 1'b0;
        start         = 1'b0;
        value         = '0;
        is_last       = 1'b0;
        held_count    = 0;
        dropped       = 1'b0;
        mismatch_seen = 1'b0;
        cycle_count   = 0;
        set_index     = 0;
        random_sent   = 0;

        // Single-word sets at the extremes and around zero carry their result in the row.
        directed_rows = '{
            '{MIN_WORD,     1'b1, 1'b1, MIN_WORD,     1'b1, 1'b0},
            '{MAX_WORD,     1'b1, 1'b1, MAX_WORD,     1'b1, 1'b0},
            '{32'sh0,       1'b1, 1'b1, 32'sh0,       1'b1, 1'b0},
            '{32'shffff_ffff, 1'b1, 1'b1, 32'shffff_ffff, 1'b1, 1'b0},
            '{32'sh7,       1'b0, 1'b0, 32'sh0,       1'b0, 1'b0},
            '{MAX_WORD,     1'b0, 1'b0, 32'sh0,       1'b0, 1'b0},
            '{MIN_WORD,     1'b0, 1'b0, 32'sh0,       1'b0, 1'b0},
            '{32'shffff_ffff, 1'b0, 1'b0, 32'sh0,     1'b0, 1'b0},
            '{32'sh0,       1'b0, 1'b0, 32'sh0,       1'b0, 1'b0},
            '{32'sh7,       1'b1, 1'b0, 32'sh0,       1'b0, 1'b0},
            '{32'sh2,       1'b0, 1'b0, 32'sh0,       1'b0, 1'b0},
            '{32'shffff_fffe, 1'b1, 1'b0, 32'sh0,     1'b0, 1'b0}
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < TABLE_ROWS; i++)
        begin
            row = directed_rows[i];
            send_word(row.word, row.last);
            if (row.typed)
            begin
                held_count      = 0;
                dropped         = 1'b0;
                typed_word.word = row.exp_word;
                typed_word.last = row.exp_last;
                typed_word.ovf  = row.exp_ovf;
                sorted_words_due.push_back(typed_word);
            end
            else
            begin
                load_word(row.word, row.last);
            end
            pause(6);
        end

        // A few sets fill the store exactly or run past it, including one whose
        // closing word is itself dropped.
        while (random_sent < RANDOM_WORDS)
        begin
            case (set_index)
                3:  set_size = DEPTH + 1;
                7:  set_size = DEPTH;
                12: set_size = DEPTH + 6;
                default:
                    if ($urandom_range(0, 24) == 0)
                        set_size = $urandom_range(DEPTH - 4, DEPTH + 4);
                    else
                        set_size = $urandom_range(1, 10);
            endcase
            for (n = 0; n < set_size; n++)
            begin
                w = random_word();
                l = (n == set_size - 1);
                send_word(w, l);
                load_word(w, l);
                random_sent++;
                pause(gap_percent(random_sent));
            end
            set_index++;
        end

        start <= 1'b0;
        while (sorted_words_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (!mismatch_seen && sorted_words_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
